// File: rtl/xcfr_pkg.sv
// shared constants and types of the xor checked frame receiver
package xcfr_pkg;

  localparam int DATA_W      = 8;
  localparam int LEN_W       = 7;
  localparam int IDX_W       = 6;
  localparam int MAX_PAYLOAD = 64;
  localparam int RAM_DEPTH   = 2 * MAX_PAYLOAD;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int DESC_DEPTH  = 2;
  localparam int OUT_DEPTH   = 4;
  localparam int CFG_IDX_W   = 1;

  localparam logic [DATA_W-1:0] HEAD_RESET = 8'h55;
  localparam logic [DATA_W-1:0] TAIL_RESET = 8'hBB;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] cmd;
    logic [LEN_W-1:0]  len;
    logic              bank;
  } desc_t;

  typedef struct packed {
    logic [DATA_W-1:0] frame_cmd;
    logic [LEN_W-1:0]  frame_len;
    logic [IDX_W-1:0]  byte_index;
    logic [DATA_W-1:0] payload_byte;
    logic              has_payload;
    logic              last_of_frame;
  } result_t;

endpackage

// File: rtl/xcfr_ram.sv
// generic single write port ram with registered read
module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/xcfr_front.sv
// frame parser: checks head, length, checksum and tail, stores data bytes
module xcfr_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [xcfr_pkg::DATA_W-1:0]     cfg_wdata,
  input  logic                            byte_vld,
  input  logic [xcfr_pkg::DATA_W-1:0]     rx_byte,
  output logic                            ram_we,
  output logic [xcfr_pkg::RAM_AW-1:0]     ram_waddr,
  output logic [xcfr_pkg::DATA_W-1:0]     ram_wdata,
  output logic                            desc_push,
  output xcfr_pkg::desc_t                 desc
);

  typedef enum logic [2:0] {
    PH_HEAD, PH_CMD, PH_LEN, PH_DATA, PH_SUM, PH_TAIL
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [xcfr_pkg::DATA_W-1:0]   head_r, head_nxt;
  logic [xcfr_pkg::DATA_W-1:0]   tail_r, tail_nxt;
  logic [xcfr_pkg::DATA_W-1:0]   cmd_r, cmd_nxt;
  logic [xcfr_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [xcfr_pkg::LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [xcfr_pkg::DATA_W-1:0]   xor_r, xor_nxt;
  logic                          bank_r, bank_nxt;
  logic                          push;

  always_comb begin
    phase_nxt = phase_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    bank_nxt  = bank_r;
    push      = 1'b0;
    if (cfg_we && cfg_idx == xcfr_pkg::REG_HEAD) begin
      head_nxt = cfg_wdata;
    end
    if (cfg_we && cfg_idx == xcfr_pkg::REG_TAIL) begin
      tail_nxt = cfg_wdata;
    end
    if (byte_vld) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (rx_byte == head_r) begin
            xor_nxt   = '0;
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if ({1'b0, rx_byte} > 9'(xcfr_pkg::MAX_PAYLOAD)) begin
            phase_nxt = PH_HEAD;
          end else begin
            len_nxt   = rx_byte[xcfr_pkg::LEN_W-1:0];
            cnt_nxt   = '0;
            phase_nxt = (rx_byte == '0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          xor_nxt = xor_r ^ rx_byte;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_nxt >= len_r) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_nxt = (rx_byte == xor_r) ? PH_TAIL : PH_HEAD;
        end
        PH_TAIL: begin
          if (rx_byte == tail_r) begin
            push     = 1'b1;
            bank_nxt = ~bank_r;
          end
          phase_nxt = PH_HEAD;
        end
        default: begin
          phase_nxt = PH_HEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      head_r  <= xcfr_pkg::HEAD_RESET;
      tail_r  <= xcfr_pkg::TAIL_RESET;
      cmd_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      xor_r   <= '0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      bank_r  <= bank_nxt;
    end
  end

  assign ram_we    = byte_vld && (phase_r == PH_DATA);
  assign ram_waddr = {bank_r, cnt_r[xcfr_pkg::IDX_W-1:0]};
  assign ram_wdata = rx_byte;
  assign desc_push = push;
  assign desc.cmd  = cmd_r;
  assign desc.len  = len_r;
  assign desc.bank = bank_r;

  a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (cnt_r < len_r && len_r <= 7'(xcfr_pkg::MAX_PAYLOAD)))
    else $error("data count out of range");

endmodule

// File: rtl/xcfr_desc_fifo.sv
// queue of checked frames between the parser and the result sequencer
module xcfr_desc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  xcfr_pkg::desc_t wdata,
  input  logic            pop,
  output xcfr_pkg::desc_t rdata,
  output logic            empty,
  output logic            full
);

  localparam int PW = $clog2(xcfr_pkg::DESC_DEPTH);
  localparam int CW = $clog2(xcfr_pkg::DESC_DEPTH + 1);

  xcfr_pkg::desc_t mem_r [xcfr_pkg::DESC_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(xcfr_pkg::DESC_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_desc_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(xcfr_pkg::DESC_DEPTH))
    else $error("descriptor queue overflow");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("frame pushed into full descriptor queue");

endmodule

// File: rtl/xcfr_back.sv
// result sequencer: reads stored data bytes and queues one result per byte (one for an empty frame)
module xcfr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          desc_empty,
  input  xcfr_pkg::desc_t               desc,
  output logic                          desc_pop,
  output logic                          ram_re,
  output logic [xcfr_pkg::RAM_AW-1:0]   ram_raddr,
  input  logic [xcfr_pkg::DATA_W-1:0]   ram_rdata,
  input  logic                          res_pop,
  output logic                          res_empty,
  output xcfr_pkg::result_t             res
);

  localparam int PW = $clog2(xcfr_pkg::OUT_DEPTH);
  localparam int CW = $clog2(xcfr_pkg::OUT_DEPTH + 1);

  logic [xcfr_pkg::IDX_W-1:0] k_r, k_nxt;
  logic                       s1_vld_r;
  xcfr_pkg::result_t          s1_r, s1_nxt;
  xcfr_pkg::result_t          out_mem_r [xcfr_pkg::OUT_DEPTH];
  xcfr_pkg::result_t          push_res;
  logic [PW-1:0]              wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       issue, last, do_pop;

  assign issue = !desc_empty &&
                 (({1'b0, count_r} + (CW+1)'(s1_vld_r)) < (CW+1)'(xcfr_pkg::OUT_DEPTH));
  assign last  = (desc.len == '0) || (({1'b0, k_r} + 7'd1) == desc.len);

  always_comb begin
    s1_nxt               = s1_r;
    k_nxt                = k_r;
    if (issue) begin
      s1_nxt.frame_cmd     = desc.cmd;
      s1_nxt.frame_len     = desc.len;
      s1_nxt.byte_index    = k_r;
      s1_nxt.payload_byte  = '0;
      s1_nxt.has_payload   = (desc.len != '0);
      s1_nxt.last_of_frame = last;
      k_nxt                = last ? '0 : k_r + 1'b1;
    end
  end

  assign desc_pop  = issue && last;
  assign ram_re    = issue;
  assign ram_raddr = {desc.bank, k_r};

  always_comb begin
    push_res              = s1_r;
    push_res.payload_byte = s1_r.has_payload ? ram_rdata : '0;
  end

  assign res_empty = (count_r == '0);
  assign do_pop    = res_pop && !res_empty;
  assign res       = out_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (s1_vld_r && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !s1_vld_r) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (s1_vld_r) begin
      out_mem_r[wr_ptr_r] <= push_res;
    end
    if (!rst_n) begin
      k_r      <= '0;
      s1_vld_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      k_r      <= k_nxt;
      s1_vld_r <= issue;
      if (s1_vld_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(xcfr_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!desc_empty && desc.len != '0) |-> ({1'b0, k_r} < desc.len))
    else $error("byte index beyond frame length");

endmodule

// File: rtl/xor_checked_frame_receiver.sv
// top level of the xor checked frame receiver
// Usage:
//   Input channel: push a received byte on in_rx_byte with in_push; the
//   transaction completes when in_full is low. Frames are head, command,
//   length (0..64), data bytes, xor checksum of the data, tail.
//   Result channel: while out_empty is low the oldest result is on the
//   out_ ports; pop with out_pop. A good frame gives one result per data
//   byte (or one result without data for length zero), last one marked.
//   Configuration: cfg_we writes cfg_wdata to register cfg_idx
//   (0 = head byte, 1 = tail byte) at once.
// Path: an accepted tail byte queues the frame descriptor; the first result
//   is staged in s1 with its ram read, then written to the result queue.
// Throughput: one byte per cycle in while in_full is low; results leave at
//   one per cycle while popped. Data is held in two 64 byte banks, so in_full
//   rises while two checked frames wait, until the older one is fully issued.
// Reset: rst_n low for one clock clears the parser to wait for a head
//   byte, empties both queues and restores head 0x55 and tail 0xBB.
// Stall: if results are not popped, the four entry result queue fills,
//   then frames back up and in_full holds the input.
module xor_checked_frame_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [xcfr_pkg::DATA_W-1:0]     cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [xcfr_pkg::DATA_W-1:0]     in_rx_byte,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [xcfr_pkg::DATA_W-1:0]     out_frame_cmd,
  output logic [xcfr_pkg::LEN_W-1:0]      out_frame_len,
  output logic [xcfr_pkg::IDX_W-1:0]      out_byte_index,
  output logic [xcfr_pkg::DATA_W-1:0]     out_payload_byte,
  output logic                            out_has_payload,
  output logic                            out_last_of_frame
);

  logic                          ram_we, ram_re;
  logic [xcfr_pkg::RAM_AW-1:0]   ram_waddr, ram_raddr;
  logic [xcfr_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;
  logic                          desc_push, desc_pop, desc_empty, desc_full;
  xcfr_pkg::desc_t               desc_w, desc_r;
  xcfr_pkg::result_t             res;

  assign in_full = desc_full;

  xcfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .byte_vld  (in_push && !desc_full),
    .rx_byte   (in_rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .desc_push (desc_push),
    .desc      (desc_w)
  );

  xcfr_ram #(
    .WIDTH (xcfr_pkg::DATA_W),
    .DEPTH (xcfr_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  xcfr_desc_fifo u_desc_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .wdata (desc_w),
    .pop   (desc_pop),
    .rdata (desc_r),
    .empty (desc_empty),
    .full  (desc_full)
  );

  xcfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_empty (desc_empty),
    .desc       (desc_r),
    .desc_pop   (desc_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_pop    (out_pop),
    .res_empty  (out_empty),
    .res        (res)
  );

  assign out_frame_cmd     = res.frame_cmd;
  assign out_frame_len     = res.frame_len;
  assign out_byte_index    = res.byte_index;
  assign out_payload_byte  = res.payload_byte;
  assign out_has_payload   = res.has_payload;
  assign out_last_of_frame = res.last_of_frame;

endmodule

// File: test/xor_checked_frame_receiver_tb.sv
// testbench for the xor checked frame receiver: byte stimulus, frame predictor, result checks
module xor_checked_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;

  typedef logic [xcfr_pkg::DATA_W-1:0] byte_t;

  typedef enum logic [2:0] {
    WAIT_HEAD, GET_CMD, GET_LEN, GET_DATA, GET_SUM, GET_TAIL
  } parse_phase_t;

  typedef enum {
    FRAME_GOOD, FRAME_BIG_LEN, FRAME_BAD_SUM, FRAME_BAD_TAIL, FRAME_CUT
  } frame_kind_t;

  class frame_scoreboard_t;
    byte_t                           head_val;
    byte_t                           tail_val;
    parse_phase_t                    phase;
    byte_t                           cmd_q;
    logic [xcfr_pkg::LEN_W-1:0]      len_q;
    logic [xcfr_pkg::LEN_W-1:0]      count_q;
    byte_t                           xor_q;
    byte_t                           data_store [xcfr_pkg::MAX_PAYLOAD];
    xcfr_pkg::result_t               expected_q [$];
    int errors;
    int frames_good;
    int frames_dropped;
    int results_checked;

    function new();
      head_val = xcfr_pkg::HEAD_RESET;
      tail_val = xcfr_pkg::TAIL_RESET;
      phase = WAIT_HEAD;
      cmd_q = '0;
      len_q = '0;
      count_q = '0;
      xor_q = '0;
      errors = 0;
      frames_good = 0;
      frames_dropped = 0;
      results_checked = 0;
    endfunction

    function void write_reg(logic [xcfr_pkg::CFG_IDX_W-1:0] idx, byte_t val);
      if (idx == xcfr_pkg::REG_HEAD) head_val = val;
      else if (idx == xcfr_pkg::REG_TAIL) tail_val = val;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(byte_t b);
      xcfr_pkg::result_t r;
      case (phase)
        WAIT_HEAD: begin
          if (b == head_val) begin
            xor_q = '0;
            phase = GET_CMD;
          end
        end
        GET_CMD: begin
          cmd_q = b;
          phase = GET_LEN;
        end
        GET_LEN: begin
          if (b > xcfr_pkg::MAX_PAYLOAD) begin
            frames_dropped++;
            phase = WAIT_HEAD;
          end else begin
            len_q = b[xcfr_pkg::LEN_W-1:0];
            count_q = '0;
            phase = (b == 0) ? GET_SUM : GET_DATA;
          end
        end
        GET_DATA: begin
          data_store[count_q[xcfr_pkg::IDX_W-1:0]] = b;
          xor_q = xor_q ^ b;
          count_q = count_q + 1'b1;
          if (count_q >= len_q) phase = GET_SUM;
        end
        GET_SUM: begin
          if (b == xor_q) begin
            phase = GET_TAIL;
          end else begin
            frames_dropped++;
            phase = WAIT_HEAD;
          end
        end
        GET_TAIL: begin
          if (b == tail_val) begin
            frames_good++;
            r.frame_cmd = cmd_q;
            r.frame_len = len_q;
            if (len_q == 0) begin
              r.byte_index = '0;
              r.payload_byte = '0;
              r.has_payload = 1'b0;
              r.last_of_frame = 1'b1;
              expected_q.push_back(r);
            end else begin
              for (int k = 0; k < len_q; k++) begin
                r.byte_index = k[xcfr_pkg::IDX_W-1:0];
                r.payload_byte = data_store[k];
                r.has_payload = 1'b1;
                r.last_of_frame = (k + 1 == len_q);
                expected_q.push_back(r);
              end
            end
          end else begin
            frames_dropped++;
          end
          phase = WAIT_HEAD;
        end
        default: phase = WAIT_HEAD;
      endcase
    endfunction

    function void check_result(xcfr_pkg::result_t got);
      xcfr_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: frame_cmd %0h byte_index %0d", got.frame_cmd, got.byte_index);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got.frame_cmd !== want.frame_cmd) begin
        $error("frame_cmd: expected %0h, got %0h", want.frame_cmd, got.frame_cmd);
        errors++;
      end
      if (got.frame_len !== want.frame_len) begin
        $error("frame_len: expected %0d, got %0d", want.frame_len, got.frame_len);
        errors++;
      end
      if (got.byte_index !== want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
        errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
        errors++;
      end
      if (got.has_payload !== want.has_payload) begin
        $error("has_payload: expected %0b, got %0b", want.has_payload, got.has_payload);
        errors++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        $error("last_of_frame: expected %0b, got %0b", want.last_of_frame, got.last_of_frame);
        errors++;
      end
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [xcfr_pkg::CFG_IDX_W-1:0]    cfg_idx = '0;
  byte_t                             cfg_wdata = '0;
  logic                              in_push = 1'b0;
  logic                              in_full;
  byte_t                             in_rx_byte = '0;
  logic                              out_empty;
  logic                              out_pop = 1'b0;
  logic [xcfr_pkg::DATA_W-1:0]       out_frame_cmd;
  logic [xcfr_pkg::LEN_W-1:0]        out_frame_len;
  logic [xcfr_pkg::IDX_W-1:0]        out_byte_index;
  logic [xcfr_pkg::DATA_W-1:0]       out_payload_byte;
  logic                              out_has_payload;
  logic                              out_last_of_frame;

  frame_scoreboard_t sb;
  byte_t cur_head = xcfr_pkg::HEAD_RESET;
  byte_t cur_tail = xcfr_pkg::TAIL_RESET;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int bytes_sent = 0;
  int hold_off_req = 0;
  int hold_left = 0;
  int held_total = 0;
  int quiet_cycles = 0;

  xor_checked_frame_receiver u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_rx_byte        (in_rx_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_frame_cmd     (out_frame_cmd),
    .out_frame_len     (out_frame_len),
    .out_byte_index    (out_byte_index),
    .out_payload_byte  (out_payload_byte),
    .out_has_payload   (out_has_payload),
    .out_last_of_frame (out_last_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input byte_t b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // fill < 0 gives random data bytes
  task automatic send_frame(input byte_t cmd, input int len,
                            input frame_kind_t kind, input int fill = -1);
    byte_t sum;
    byte_t d;
    int n_data;
    sum = '0;
    send_byte(cur_head);
    send_byte(cmd);
    send_byte(byte_t'(len));
    if (kind == FRAME_BIG_LEN) return;
    n_data = (kind == FRAME_CUT) ? $urandom_range(len) : len;
    for (int i = 0; i < n_data; i++) begin
      d = (fill < 0) ? byte_t'($urandom) : byte_t'(fill);
      sum = sum ^ d;
      send_byte(d);
    end
    if (kind == FRAME_CUT) return;
    send_byte((kind == FRAME_BAD_SUM) ? sum ^ (8'h01 << $urandom_range(7)) : sum);
    send_byte((kind == FRAME_BAD_TAIL) ? cur_tail ^ byte_t'($urandom_range(255, 1))
                                       : cur_tail);
  endtask

  task automatic send_random_unit();
    int pick;
    pick = $urandom_range(99);
    if (pick < 68) send_frame(byte_t'($urandom), $urandom_range(8), FRAME_GOOD);
    else if (pick < 76) send_frame(byte_t'($urandom), $urandom_range(8), FRAME_BAD_SUM);
    else if (pick < 84) send_frame(byte_t'($urandom), $urandom_range(8), FRAME_BAD_TAIL);
    else if (pick < 89) send_frame(byte_t'($urandom),
                                   $urandom_range(255, xcfr_pkg::MAX_PAYLOAD + 1),
                                   FRAME_BIG_LEN);
    else if (pick < 94) send_frame(byte_t'($urandom), $urandom_range(8, 1), FRAME_CUT);
    else repeat ($urandom_range(3, 1)) send_byte(byte_t'($urandom));
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_markers(input byte_t head, input byte_t tail);
    cfg_we <= 1'b1;
    cfg_idx <= xcfr_pkg::REG_HEAD;
    cfg_wdata <= head;
    @(posedge clk);
    cfg_idx <= xcfr_pkg::REG_TAIL;
    cfg_wdata <= tail;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(xcfr_pkg::REG_HEAD, head);
    sb.write_reg(xcfr_pkg::REG_TAIL, tail);
    cur_head = head;
    cur_tail = tail;
  endtask

  task automatic run_phase(input int n_items);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_items) send_random_unit();
    drain();
  endtask

  initial begin
    xcfr_pkg::result_t got;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got.frame_cmd = out_frame_cmd;
        got.frame_len = out_frame_len;
        got.byte_index = out_byte_index;
        got.payload_byte = out_payload_byte;
        got.has_payload = out_has_payload;
        got.last_of_frame = out_last_of_frame;
        sb.check_result(got);
      end
      if (hold_off_req != 0) begin
        hold_off_req = 0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        held_total++;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // ends the run when no transaction completes for too long
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("xor_checked_frame_receiver_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under the reset markers
    send_byte(8'hAA);
    send_frame(8'h00, 0, FRAME_GOOD);
    send_frame(cur_head, 1, FRAME_GOOD, 8'hFF);
    send_frame(8'h5A, xcfr_pkg::MAX_PAYLOAD + 1, FRAME_BIG_LEN);
    send_frame(8'h3C, 0, FRAME_BAD_SUM);
    send_frame(8'hFF, 0, FRAME_BAD_TAIL);
    send_frame(byte_t'($urandom), xcfr_pkg::MAX_PAYLOAD, FRAME_GOOD);
    drain();

    set_markers(8'h00, 8'hFF);
    send_idle_pct = 47;
    pop_stall_pct = 0;
    run_phase(10);

    set_markers(8'hFF, 8'h00);
    send_idle_pct = 0;
    pop_stall_pct = 47;
    hold_off_req = 1;
    run_phase(40);

    set_markers(byte_t'($urandom), byte_t'($urandom));
    send_idle_pct = 7;
    pop_stall_pct = 7;
    run_phase(10);

    sb.close_out();
    $display("covered %0d bytes under four head/tail marker settings, all-zero and all-one included",
             bytes_sent);
    $display("%0d frames delivered, %0d dropped, %0d results checked, %0d cycles of output hold-off",
             sb.frames_good, sb.frames_dropped, sb.results_checked, held_total);
    if (sb.errors == 0) begin
      $display("xor_checked_frame_receiver_tb: PASS");
    end else begin
      $display("xor_checked_frame_receiver_tb: FAIL");
    end
    $finish;
  end

endmodule
